@@ src/rcpwm_pkg.sv @@
// Shared types and constants for the chained RC PWM decoder.
`default_nettype none

package rcpwm_pkg;

    // Width of the internal time arithmetic; timestamps wrap at this width.
    localparam int TIME_W  = 32;
    localparam int TS_W    = 32;
    localparam int OUT_W   = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W  = 3;
    localparam int NUM_END = 5;
    localparam int S_DATA_W = ((TS_W + 7) / 8) * 8;
    localparam int M_BITS   = 3 * OUT_W + 3;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ON_TIME      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_GAP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0] MAX_ON_TIME_RST      = 16'd2500;
    localparam logic [CFG_W-1:0] CHANNEL_GAP_RST      = 16'd0;
    localparam logic [CFG_W-1:0] SWITCH_THRESHOLD_RST = 16'd1500;

    typedef enum logic [MODE_W-1:0] {
        MODE_CH1 = 3'd0,
        MODE_CH2 = 3'd1,
        MODE_CH3 = 3'd2,
        MODE_CH4 = 3'd3,
        MODE_CH5 = 3'd4,
        MODE_CH6 = 3'd5
    } mode_t;

    typedef struct packed {
        logic [CFG_W-1:0] max_on_time;
        logic [CFG_W-1:0] channel_gap;
        logic [CFG_W-1:0] switch_threshold;
    } cfg_t;

    typedef struct packed {
        logic             switch_six;
        logic             switch_five;
        logic             switch_four;
        logic [OUT_W-1:0] width_three;
        logic [OUT_W-1:0] width_two;
        logic [OUT_W-1:0] width_one;
    } result_t;

endpackage

`default_nettype wire

@@ src/rcpwm_core.sv @@
// Decoder state and per-edge update: start/end times, widths and switch states.
`default_nettype none

module rcpwm_core
    import rcpwm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [TS_W-1:0]   timestamp,
    input  wire cfg_t              cfg,
    output result_t                res_next
);

    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] end_reg [NUM_END];
    logic [TIME_W-1:0] end_next [NUM_END];
    logic [TIME_W-1:0] width_reg [3];
    logic [TIME_W-1:0] width_next [3];
    logic [2:0]        sw_reg, sw_next;

    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] prev_end;
    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] chained;
    logic              sw_on;

    assign now         = TIME_W'(timestamp);
    assign since_start = now - start_reg;
    assign chained     = now - prev_end - TIME_W'(cfg.channel_gap);
    assign sw_on       = chained >= TIME_W'(cfg.switch_threshold);

    // end time of the channel before the one that fired
    always_comb begin
        unique case (mode_t'(mode))
            MODE_CH2: prev_end = end_reg[0];
            MODE_CH3: prev_end = end_reg[1];
            MODE_CH4: prev_end = end_reg[2];
            MODE_CH5: prev_end = end_reg[3];
            MODE_CH6: prev_end = end_reg[4];
            default:  prev_end = end_reg[0];
        endcase
    end

    always_comb begin
        start_next = start_reg;
        end_next   = end_reg;
        width_next = width_reg;
        sw_next    = sw_reg;
        if (en) begin
            unique case (mode_t'(mode))
                MODE_CH1: begin
                    if (since_start > TIME_W'(cfg.max_on_time)) begin
                        start_next = now;
                    end else begin
                        end_next[0]   = now;
                        width_next[0] = since_start;
                    end
                end
                MODE_CH2: begin
                    end_next[1]   = now;
                    width_next[1] = chained;
                end
                MODE_CH3: begin
                    end_next[2]   = now;
                    width_next[2] = chained;
                end
                MODE_CH4: begin
                    end_next[3] = now;
                    sw_next[0]  = sw_on;
                end
                MODE_CH5: begin
                    end_next[4] = now;
                    sw_next[1]  = sw_on;
                end
                MODE_CH6: begin
                    sw_next[2] = sw_on;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            end_reg   <= '{default: '0};
            width_reg <= '{default: '0};
            sw_reg    <= '0;
        end else begin
            start_reg <= start_next;
            end_reg   <= end_next;
            width_reg <= width_next;
            sw_reg    <= sw_next;
        end
    end

    assign res_next.width_one   = OUT_W'(width_next[0]);
    assign res_next.width_two   = OUT_W'(width_next[1]);
    assign res_next.width_three = OUT_W'(width_next[2]);
    assign res_next.switch_four = sw_next[0];
    assign res_next.switch_five = sw_next[1];
    assign res_next.switch_six  = sw_next[2];

endmodule

`default_nettype wire

@@ src/rc_pwm_chain_decoder.sv @@
// Throughput: one request per cycle while the output is not stalled;
// the state update is a single registered pass.
// Input register feeds the decode logic, whose result lands in the output register.
// Reset (aresetn low, synchronous) empties both registers, zeroes all times,
// widths and switch states, and loads the register defaults.
// Top level of the chained RC PWM decoder.
`default_nettype none

module rc_pwm_chain_decoder
    import rcpwm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // [31:0] timestamp
    input  wire logic [MODE_W-1:0]    s_tuser,   // [2:0] mode
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [31:0] width_one, [63:32] width_two, [95:64] width_three,
    // [96] switch_four, [97] switch_five, [98] switch_six, rest zero
    output logic [M_DATA_W-1:0]       m_tdata,
    // configuration writes
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [MODE_W-1:0] in_mode_reg;
    logic [TS_W-1:0]   in_ts_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    result_t           res_next;
    logic              advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_on_time      <= MAX_ON_TIME_RST;
            cfg_reg.channel_gap      <= CHANNEL_GAP_RST;
            cfg_reg.switch_threshold <= SWITCH_THRESHOLD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_ON_TIME:      cfg_reg.max_on_time      <= cfg_data;
                CFG_CHANNEL_GAP:      cfg_reg.channel_gap      <= cfg_data;
                CFG_SWITCH_THRESHOLD: cfg_reg.switch_threshold <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_ts_reg   <= s_tdata[TS_W-1:0];
        end
    end

    rcpwm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (in_valid_reg && advance),
        .mode      (in_mode_reg),
        .timestamp (in_ts_reg),
        .cfg       (cfg_reg),
        .res_next  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_res_reg);

endmodule

`default_nettype wire

@@ src/rcpwm_checker.sv @@
// Port-level assertions for the chained RC PWM decoder, bound to the top level.
`default_nettype none

module rcpwm_checker
    import rcpwm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // back-pressure only comes from a full output stalled downstream
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("request refused without output stall");

    // every accepted request is followed by a valid result
    a_result_due: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("accepted request produced no result");

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rc_pwm_chain_decoder rcpwm_checker u_rcpwm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
